>>> design/dart_pkg.sv
`default_nettype none

package dart_pkg;

  localparam int CLOCK_RATE_HZ = 4194304;
  localparam int DIV_PERIOD = 256;

  localparam int DIV_CD_W = 10;
  localparam int CNT_CD_W = 12;
  localparam int PERIOD_W = 11;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  localparam logic [1:0] SEL_DIVIDER = 2'd0;
  localparam logic [1:0] SEL_COUNTER = 2'd1;
  localparam logic [1:0] SEL_MODULO  = 2'd2;
  localparam logic [1:0] SEL_CONTROL = 2'd3;

  localparam logic [7:0] CTRL_ENABLE_MASK = 8'h04;
  localparam logic [7:0] CTRL_PERIOD_MASK = 8'h03;
  localparam logic [7:0] COUNTER_TOP      = 8'hFF;

  localparam int PERIOD_SEL0 = CLOCK_RATE_HZ / 4096;
  localparam int PERIOD_SEL1 = CLOCK_RATE_HZ / 262144;
  localparam int PERIOD_SEL2 = CLOCK_RATE_HZ / 65536;
  localparam int PERIOD_SEL3 = CLOCK_RATE_HZ / 16384;

  function automatic logic [PERIOD_W-1:0] period_for(input logic [1:0] sel);
    logic [PERIOD_W-1:0] p;
    unique case (sel)
      2'd0:    p = PERIOD_W'(PERIOD_SEL0);
      2'd1:    p = PERIOD_W'(PERIOD_SEL1);
      2'd2:    p = PERIOD_W'(PERIOD_SEL2);
      default: p = PERIOD_W'(PERIOD_SEL3);
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> design/dart_req_if.sv
`default_nettype none

interface dart_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [1:0] reg_select;
  logic [7:0] write_data;
  logic [7:0] elapsed_cycles;

  modport source (output valid, output action, output reg_select, output write_data,
                  output elapsed_cycles, input ready);
  modport sink (input valid, input action, input reg_select, input write_data,
                input elapsed_cycles, output ready);
endinterface

`default_nettype wire

>>> design/dart_rsp_if.sv
`default_nettype none

interface dart_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       timer_irq;

  modport source (output valid, output read_data, output timer_irq, input ready);
  modport sink (input valid, input read_data, input timer_irq, output ready);
endinterface

`default_nettype wire

>>> design/divider_and_reload_timer.sv
// Divider and reload timer with divider, counter, modulo and control registers.
// The request channel carries one item per access: a tick with an elapsed
// cycle count, a register read or a register write. Every request item gives
// exactly one item on the response channel, holding the read byte and the
// overflow interrupt flag.
// A read or write response is valid in the cycle after acceptance. A tick
// moves to the count state and stays there while it crosses counter periods,
// since a single adder adds the period back to the counter countdown once per
// cycle and advances the counter byte with it. At the shortest period a tick
// with an elapsed count of 255 crosses up to 16 periods.
// The block takes one request item at a time. A finished response sits in an
// output register, and the next request is accepted while it is being taken.
// When the receiver stalls, the response is held and no further request is
// accepted until the output register is free.
// Reset clears all four registers, both countdowns and the counter period, so
// the counter starts disabled, and it empties the output register.
`default_nettype none

module divider_and_reload_timer
  import dart_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  dart_req_if.sink    request,
  dart_rsp_if.source  response
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_COUNT = 2'b10
  } state_t;

  state_t state;

  logic [7:0] divider_byte;
  logic [7:0] counter_byte;
  logic [7:0] modulo_byte;
  logic [7:0] control_byte;
  logic signed [DIV_CD_W-1:0] divider_countdown;
  logic signed [CNT_CD_W-1:0] counter_countdown;
  logic [PERIOD_W-1:0] counter_period;
  logic irq_seen;

  logic       rsp_valid;
  logic [7:0] rsp_data;
  logic       rsp_irq;

  logic out_free;
  logic accept;
  logic counter_on;
  logic counter_due;
  logic rsp_load;

  logic signed [CNT_CD_W-1:0] div_sub;
  logic signed [CNT_CD_W-1:0] div_wrap;
  logic signed [DIV_CD_W-1:0] divider_countdown_next;
  logic [PERIOD_W-1:0]        period_next;

  localparam logic signed [CNT_CD_W-1:0] DIV_MIN_WIDE = -(CNT_CD_W'(1) <<< (DIV_CD_W - 1));

  assign out_free = !rsp_valid || response.ready;
  assign request.ready = (state == S_IDLE) && out_free;
  assign accept = request.valid && request.ready;

  assign response.valid = rsp_valid;
  assign response.read_data = rsp_data;
  assign response.timer_irq = rsp_irq;

  assign counter_on = (counter_period != '0);
  assign counter_due = counter_on && (counter_countdown <= 0);

  assign rsp_load = (accept && (request.action != ACT_TICK)) ||
                    ((state == S_COUNT) && !counter_due && out_free);

  always_comb begin
    div_sub = CNT_CD_W'(divider_countdown) - $signed({4'b0, request.elapsed_cycles});
    div_wrap = div_sub + CNT_CD_W'(DIV_PERIOD);
    if (div_sub > 0) begin
      divider_countdown_next = div_sub[DIV_CD_W-1:0];
    end else if (div_wrap < DIV_MIN_WIDE) begin
      divider_countdown_next = DIV_MIN_WIDE[DIV_CD_W-1:0];
    end else begin
      divider_countdown_next = div_wrap[DIV_CD_W-1:0];
    end
    if ((request.write_data & CTRL_ENABLE_MASK) != 8'h00) begin
      period_next = period_for(request.write_data[1:0] & CTRL_PERIOD_MASK[1:0]);
    end else begin
      period_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
      rsp_data <= 8'h00;
      rsp_irq <= 1'b0;
      irq_seen <= 1'b0;
      divider_byte <= 8'h00;
      counter_byte <= 8'h00;
      modulo_byte <= 8'h00;
      control_byte <= 8'h00;
      divider_countdown <= '0;
      counter_countdown <= '0;
      counter_period <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && response.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rsp_irq <= 1'b0;
            priority if (request.action == ACT_TICK) begin
              divider_countdown <= divider_countdown_next;
              if (div_sub <= 0) begin
                divider_byte <= divider_byte + 8'd1;
              end
              if (counter_on) begin
                counter_countdown <= counter_countdown
                                     - $signed({4'b0, request.elapsed_cycles});
              end
              irq_seen <= 1'b0;
              state <= S_COUNT;
            end else if (request.action == ACT_READ) begin
              unique case (request.reg_select)
                SEL_DIVIDER: rsp_data <= divider_byte;
                SEL_COUNTER: rsp_data <= counter_byte;
                SEL_MODULO:  rsp_data <= modulo_byte;
                default:     rsp_data <= control_byte;
              endcase
            end else if (request.action == ACT_WRITE) begin
              rsp_data <= 8'h00;
              unique case (request.reg_select)
                SEL_DIVIDER: divider_byte <= 8'h00;
                SEL_COUNTER: counter_byte <= request.write_data;
                SEL_MODULO:  modulo_byte <= request.write_data;
                default: begin
                  control_byte <= request.write_data;
                  counter_period <= period_next;
                  counter_countdown <= CNT_CD_W'(period_next);
                end
              endcase
            end else begin
              rsp_data <= 8'h00;
            end
          end
        end
        S_COUNT: begin
          if (counter_due) begin
            if (counter_byte == COUNTER_TOP) begin
              counter_byte <= modulo_byte;
              irq_seen <= 1'b1;
            end else begin
              counter_byte <= counter_byte + 8'd1;
            end
            counter_countdown <= counter_countdown + CNT_CD_W'(counter_period);
          end else if (out_free) begin
            rsp_data <= 8'h00;
            rsp_irq <= irq_seen;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The period only changes through an accepted control write.
  assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(counter_period))
    else $error("counter period changed without a write");

  // Between items an enabled counter always has a positive countdown.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && counter_on |-> counter_countdown > 0)
    else $error("enabled counter idles with a spent countdown");

  // A tick ends as soon as no period is left to cross and the output is free.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_COUNT) && !counter_due && out_free |=> (state == S_IDLE) && rsp_valid)
    else $error("tick did not complete");

  // An interrupt only comes with a tick, whose read byte is zero.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_irq |-> rsp_data == 8'h00)
    else $error("interrupt reported with read data");

endmodule

`default_nettype wire
